// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the sonar hit to world point unit.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHWP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHWP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/shwp_pkg.sv =====
// Package for the sonar hit to world point unit: constants, types, tables.
// No dependencies.
package shwp_pkg;

    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_POS_WIDTH     = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS       = 2'd0,
        CFG_MAX_RANGE    = 2'd1,
        CFG_MIN_INTERVAL = 2'd2
    } cfg_idx_t;

    localparam logic [11:0] RADIUS_RESET       = 12'd250;
    localparam logic [12:0] MAX_RANGE_RESET    = 13'd2000;
    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd1500;

    // angle units
    localparam logic [16:0] TURN_CENTIDEG  = 17'd36000;
    localparam logic [31:0] HALF_CENTIDEG  = 32'd18000;
    localparam logic [29:0] GAIN_Q30       = 30'd652032874;

    localparam int ANG_W = 34;
    localparam int XY_W  = 34;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef struct packed {
        logic              hit;
        logic signed [7:0] deg;
    } bearing_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROT,
        ST_OUT
    } seq_state_t;

    function automatic bearing_t bearing_lookup(input logic [3:0] idx);
        bearing_t b;
        b.hit = 1'b1;
        unique case (idx)
            4'd0, 4'd15: b.deg = 8'sd90;
            4'd1:        b.deg = 8'sd50;
            4'd2:        b.deg = 8'sd30;
            4'd3:        b.deg = 8'sd10;
            4'd4:        b.deg = -8'sd10;
            4'd5:        b.deg = -8'sd30;
            4'd6:        b.deg = -8'sd50;
            4'd7, 4'd8:  b.deg = -8'sd90;
            default:
            begin
                b.hit = 1'b0;
                b.deg = 8'sd0;
            end
        endcase
        return b;
    endfunction

    // arctangent of 2^-i, full turn = 2^32
    function automatic logic [29:0] atan_lookup(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/shwp_channels.sv =====
// Handshake channels of the sonar hit to world point unit.
// Depends on nothing; widths follow POS_WIDTH where positions are carried.
interface shwp_in_if #(parameter int POS_WIDTH = 24);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] robot_x_mm;
    logic signed [POS_WIDTH-1:0] robot_y_mm;
    logic signed [15:0]          heading_centideg;
    logic        [12:0]          range_mm;
    logic        [3:0]           sonar_index;
    logic        [31:0]          time_ms;

    modport source (output valid, robot_x_mm, robot_y_mm, heading_centideg,
                    range_mm, sonar_index, time_ms, input ready);
    modport sink   (input valid, robot_x_mm, robot_y_mm, heading_centideg,
                    range_mm, sonar_index, time_ms, output ready);
endinterface

interface shwp_out_if #(parameter int POS_WIDTH = 24);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] point_x_mm;
    logic signed [POS_WIDTH-1:0] point_y_mm;
    logic        [12:0]          hit_range_mm;
    logic signed [7:0]           bearing_deg;

    modport source (output valid, point_x_mm, point_y_mm, hit_range_mm, bearing_deg,
                    input ready);
    modport sink   (input valid, point_x_mm, point_y_mm, hit_range_mm, bearing_deg,
                    output ready);
endinterface

interface shwp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [15:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/shwp_angle_div.sv =====
// Bit-serial restoring divider: binary angle = (t * 2^32 + 18000) / 36000.
// Depends on shwp_pkg.
module shwp_angle_div
    import shwp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [15:0]  t_centideg,
    output unit_status_t status,
    output logic [31:0]  quot
);

    logic [16:0] rem_reg, rem_next;
    logic [31:0] quot_reg, quot_next;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [16:0] shifted;
    logic        qbit;

    // next dividend bit comes from the low word, which holds 18000
    always_comb
    begin
        shifted = {rem_reg[15:0], HALF_CENTIDEG[~cnt_reg]};
        qbit    = (shifted >= TURN_CENTIDEG);
        rem_next  = qbit ? (shifted - TURN_CENTIDEG) : shifted;
        quot_next = {quot_reg[30:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, t_centideg};
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign status = '{busy: busy_reg, done: done_reg};
    assign quot   = quot_reg;

endmodule

// ===== rtl/shwp_radius_mul.sv =====
// Bit-serial shift-add multiply: r = (dist * gain + 2^13) >> 14, Q16 with gain.
// Depends on shwp_pkg.
module shwp_radius_mul
    import shwp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [13:0]  dist_mm,
    output unit_status_t status,
    output logic [29:0]  r_q16
);

    logic [13:0] m_reg;
    logic [43:0] addend_reg, acc_reg, acc_next, rnd;
    logic [29:0] r_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg, done_reg;

    always_comb
    begin
        acc_next = acc_reg + (m_reg[0] ? addend_reg : 44'd0);
        rnd      = acc_next + 44'd8192;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd13)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg      <= dist_mm;
            addend_reg <= 44'(GAIN_Q30);
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            m_reg      <= m_reg >> 1;
            addend_reg <= addend_reg << 1;
            acc_reg    <= acc_next;
            if (cnt_reg == 4'd13)
                r_reg <= rnd[43:14];
        end
    end

    assign status = '{busy: busy_reg, done: done_reg};
    assign r_q16  = r_reg;

endmodule

// ===== rtl/shwp_cordic.sv =====
// Iterative CORDIC rotation, one stage per cycle, with quarter-turn fold on load.
// Depends on shwp_pkg.
module shwp_cordic
    import shwp_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [31:0]            angle,
    input  logic [29:0]            r_q16,
    output unit_status_t           status,
    output logic signed [XY_W-1:0] x_q16,
    output logic signed [XY_W-1:0] y_q16
);

    localparam int CW = $clog2(CORDIC_STAGES);

    logic signed [XY_W-1:0]  x_reg, y_reg, dx, dy, r_s;
    logic signed [ANG_W-1:0] a_reg, a_in, at;
    logic [CW-1:0]           cnt_reg;
    logic                    busy_reg, done_reg;

    always_comb
    begin
        a_in = ANG_W'(signed'(angle));
        r_s  = signed'(XY_W'(r_q16));
        at   = signed'(ANG_W'(atan_lookup(5'(cnt_reg))));
        dx   = y_reg >>> cnt_reg;
        dy   = x_reg >>> cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(CORDIC_STAGES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // fold into the right half plane
            if (a_in > QUARTER_TURN)
            begin
                x_reg <= '0;
                y_reg <= r_s;
                a_reg <= a_in - QUARTER_TURN;
            end
            else if (a_in < -QUARTER_TURN)
            begin
                x_reg <= '0;
                y_reg <= -r_s;
                a_reg <= a_in + QUARTER_TURN;
            end
            else
            begin
                x_reg <= r_s;
                y_reg <= '0;
                a_reg <= a_in;
            end
        end
        else if (busy_reg)
        begin
            if (a_reg >= 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                a_reg <= a_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                a_reg <= a_reg + at;
            end
        end
    end

    assign status = '{busy: busy_reg, done: done_reg};
    assign x_q16  = x_reg;
    assign y_q16  = y_reg;

endmodule

// ===== rtl/sonar_hit_to_world_point_unit.sv =====
// Top level of the sonar hit to world point unit: gating, bearing, sequencing, output.
// Depends on shwp_pkg, shwp_channels, shwp_angle_div, shwp_radius_mul, shwp_cordic, assert_macros.svh.
//
//   channel   dir   contents
//   reading   in    robot pose, range, sonar index, timestamp
//   point     out   world point, range, bearing
//   cfg       in    register writes (addr, data), always ready
//
// An emitted item passes through the bit-serial angle divider, then through the CORDIC at
// one CORDIC stage per cycle, then into the output register.
// A reading that is not emitted leaves the unit idle. One item is in flight at a time.
// The finished result waits in the output register while the next reading is taken.
// Reset clears the control state and loads the register defaults.
module sonar_hit_to_world_point_unit
    import shwp_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int POS_WIDTH     = DEF_POS_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    shwp_in_if.sink             reading,
    shwp_out_if.source          point,
    shwp_cfg_if.sink            cfg
);

`include "assert_macros.svh"

    localparam int SUM_W = ((POS_WIDTH > 18) ? POS_WIDTH : 18) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    seq_state_t state_reg, state_next;

    logic [11:0] radius_reg;
    logic [12:0] max_range_reg;
    logic [15:0] min_interval_reg;
    logic [31:0] last_emit_reg;
    logic signed [7:0] last_bearing_reg;

    logic signed [POS_WIDTH-1:0] rx_reg, ry_reg;
    logic [12:0]       hit_range_reg;
    logic signed [7:0] bearing_reg;

    logic                        out_valid_reg;
    logic signed [POS_WIDTH-1:0] point_x_reg, point_y_reg;
    logic [12:0]                 point_range_reg;
    logic signed [7:0]           point_bearing_reg;

    logic        acc, gate_ok, cordic_start, out_load;
    logic [31:0] elapsed;
    bearing_t    lk;
    logic signed [7:0]  bear;
    logic signed [17:0] t_raw;
    logic [15:0] t_mod;
    logic [13:0] dist_sum;

    unit_status_t div_st, mul_st, cor_st;
    logic [31:0]  quot;
    logic [29:0]  r_q16;
    logic signed [XY_W-1:0]  x_q16, y_q16, x_rnd, y_rnd;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [POS_WIDTH-1:0] sat_x, sat_y;

    // ---- accept-cycle work ----
    always_comb
    begin
        acc     = reading.valid && reading.ready;
        elapsed = reading.time_ms - last_emit_reg;
        gate_ok = (elapsed > 32'(min_interval_reg)) && (reading.range_mm < max_range_reg);
        lk      = bearing_lookup(reading.sonar_index);
        bear    = lk.hit ? lk.deg : last_bearing_reg;
        t_raw   = 18'(reading.heading_centideg) + 18'(bear) * 18'sd100;
        // reduce into one turn
        if (t_raw < -18'sd36000)
            t_mod = 16'(t_raw + 18'sd72000);
        else if (t_raw < 18'sd0)
            t_mod = 16'(t_raw + 18'sd36000);
        else if (t_raw >= 18'sd36000)
            t_mod = 16'(t_raw - 18'sd36000);
        else
            t_mod = 16'(t_raw);
        dist_sum = 14'(reading.range_mm) + 14'(radius_reg);
    end

    shwp_angle_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (acc && gate_ok),
        .t_centideg (t_mod),
        .status     (div_st),
        .quot       (quot)
    );

    shwp_radius_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (acc && gate_ok),
        .dist_mm (dist_sum),
        .status  (mul_st),
        .r_q16   (r_q16)
    );

    shwp_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  (quot),
        .r_q16  (r_q16),
        .status (cor_st),
        .x_q16  (x_q16),
        .y_q16  (y_q16)
    );

    // ---- round, translate, saturate ----
    always_comb
    begin
        x_rnd = (x_q16 + XY_W'(32768)) >>> 16;
        y_rnd = (y_q16 + XY_W'(32768)) >>> 16;
        sum_x = SUM_W'(signed'(x_rnd[17:0])) + SUM_W'(rx_reg);
        sum_y = SUM_W'(signed'(y_rnd[17:0])) + SUM_W'(ry_reg);
        if (sum_x > SAT_HI)
            sat_x = SAT_HI[POS_WIDTH-1:0];
        else if (sum_x < SAT_LO)
            sat_x = SAT_LO[POS_WIDTH-1:0];
        else
            sat_x = sum_x[POS_WIDTH-1:0];
        if (sum_y > SAT_HI)
            sat_y = SAT_HI[POS_WIDTH-1:0];
        else if (sum_y < SAT_LO)
            sat_y = SAT_LO[POS_WIDTH-1:0];
        else
            sat_y = sum_y[POS_WIDTH-1:0];
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (acc && gate_ok) state_next = ST_DIV;
            ST_DIV:  if (div_st.done)    state_next = ST_ROT;
            ST_ROT:  if (cor_st.done)    state_next = ST_OUT;
            ST_OUT:  if (out_load)       state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        reading.ready = (state_reg == ST_IDLE);
        cordic_start  = (state_reg == ST_DIV) && div_st.done;
        out_load      = (state_reg == ST_OUT) && (!out_valid_reg || point.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            radius_reg       <= RADIUS_RESET;
            max_range_reg    <= MAX_RANGE_RESET;
            min_interval_reg <= MIN_INTERVAL_RESET;
            last_emit_reg    <= '0;
            last_bearing_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.addr)
                    CFG_RADIUS:       radius_reg       <= cfg.data[11:0];
                    CFG_MAX_RANGE:    max_range_reg    <= cfg.data[12:0];
                    CFG_MIN_INTERVAL: min_interval_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (acc && gate_ok)
            begin
                last_emit_reg <= reading.time_ms;
                if (lk.hit)
                    last_bearing_reg <= lk.deg;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (point.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && gate_ok)
        begin
            rx_reg        <= reading.robot_x_mm;
            ry_reg        <= reading.robot_y_mm;
            hit_range_reg <= reading.range_mm;
            bearing_reg   <= bear;
        end
        if (out_load)
        begin
            point_x_reg       <= sat_x;
            point_y_reg       <= sat_y;
            point_range_reg   <= hit_range_reg;
            point_bearing_reg <= bearing_reg;
        end
    end

    assign cfg.ready          = 1'b1;
    assign point.valid        = out_valid_reg;
    assign point.point_x_mm   = point_x_reg;
    assign point.point_y_mm   = point_y_reg;
    assign point.hit_range_mm = point_range_reg;
    assign point.bearing_deg  = point_bearing_reg;

    `SHWP_ASSERT_NEXT(a_skip_stays_idle, acc && !gate_ok, state_reg == ST_IDLE,
        "skipped reading left idle")
    `SHWP_ASSERT_SAME(a_mul_before_div, div_st.done, !mul_st.busy,
        "radius multiply still busy when angle ready")
    `SHWP_ASSERT_SAME(a_div_in_div_state, div_st.done, state_reg == ST_DIV,
        "divider finished outside its state")
    `SHWP_ASSERT_NEXT(a_emit_time_kept, acc && gate_ok, last_emit_reg == $past(reading.time_ms),
        "emit time not recorded")

endmodule
